// ===== src/ipv6hv_pkg.sv =====
// constants, phase encoding and character class helpers for the ipv6 host validator
// no dependencies
package ipv6hv_pkg;

  localparam int unsigned PortWidth = 16;
  localparam logic [PortWidth-1:0] PortMax = 16'hFFFF;

  localparam logic [7:0] CharOpen  = 8'h5B;  // '['
  localparam logic [7:0] CharClose = 8'h5D;  // ']'
  localparam logic [7:0] CharColon = 8'h3A;  // ':'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  typedef enum logic [4:0] {
    PhOpen   = 5'b00001,
    PhInside = 5'b00010,
    PhClosed = 5'b00100,
    PhPort   = 5'b01000,
    PhBad    = 5'b10000
  } phase_e;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CharLowA) && (c <= CharLowF)) ||
           ((c >= CharUpA) && (c <= CharUpF));
  endfunction

endpackage

// ===== src/ipv6_host_validator.sv =====
// top level of the bracketed ipv6 host validator: per-byte parser state and verdict register
// depends on ipv6hv_pkg

// Checks a host string of the form "[" hex-and-colons "]" with an optional ":port",
// one byte per item, and returns one verdict item on the byte marked end_of_string.
// Each byte updates the parser state by a single pass of
// logic at the input handshake, and the verdict goes into an output register that
// is held while the far side stalls. A new item is taken every cycle; input is
// stalled only when a verdict is waiting and the output side is stalling.
// After a verdict the parser is back in its reset state for the next string.
module ipv6_host_validator import ipv6hv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       host_ok_o
);

  phase_e                 phase_q, phase_d;
  logic                   prev_colon_q, prev_colon_d;
  logic                   dbl_colon_q, dbl_colon_d;
  logic                   any_colon_q, any_colon_d;
  logic [PortWidth-1:0]   port_value_q, port_value_d;
  logic                   port_digit_q, port_digit_d;
  logic                   out_valid_q, out_valid_d;
  logic                   host_ok_q, host_ok_d;

  logic                   in_accept;
  logic [3:0]             digit;
  logic [PortWidth+3:0]   port_sum;
  logic                   verdict;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign digit    = 4'(char_byte_i - CharZero);
  assign port_sum = (20'(port_value_q) * 20'd10) + 20'(digit);

  // next parser state for the incoming byte
  always_comb begin
    phase_d      = phase_q;
    prev_colon_d = prev_colon_q;
    dbl_colon_d  = dbl_colon_q;
    any_colon_d  = any_colon_q;
    port_value_d = port_value_q;
    port_digit_d = port_digit_q;
    unique case (phase_q)
      PhOpen: begin
        phase_d = (char_byte_i == CharOpen) ? PhInside : PhBad;
      end
      PhInside: begin
        if (char_byte_i == CharClose) begin
          phase_d = any_colon_q ? PhClosed : PhBad;
        end else if (char_byte_i == CharColon) begin
          // a run of three colons is a second pair
          if (prev_colon_q) begin
            if (dbl_colon_q) phase_d = PhBad;
            dbl_colon_d = 1'b1;
          end
          any_colon_d  = 1'b1;
          prev_colon_d = 1'b1;
        end else if (is_hex(char_byte_i)) begin
          prev_colon_d = 1'b0;
        end else begin
          phase_d = PhBad;
        end
      end
      PhClosed: begin
        phase_d = (char_byte_i == CharColon) ? PhPort : PhBad;
      end
      PhPort: begin
        if (is_dec(char_byte_i)) begin
          // saturate so that an oversized port stays rejected
          port_value_d = (port_sum > 20'(PortMax)) ? PortMax : port_sum[PortWidth-1:0];
          port_digit_d = 1'b1;
        end else begin
          phase_d = PhBad;
        end
      end
      default: phase_d = PhBad;
    endcase
  end

  assign verdict = (phase_d == PhClosed) ||
                   ((phase_d == PhPort) && port_digit_d &&
                    (port_value_d > 16'd1) && (port_value_d < PortMax));

  always_comb begin
    out_valid_d = out_valid_q;
    host_ok_d   = host_ok_q;
    if (in_accept && end_of_string_i) begin
      out_valid_d = 1'b1;
      host_ok_d   = verdict;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhOpen;
      prev_colon_q <= 1'b0;
      dbl_colon_q  <= 1'b0;
      any_colon_q  <= 1'b0;
      port_value_q <= '0;
      port_digit_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        if (end_of_string_i) begin
          phase_q      <= PhOpen;
          prev_colon_q <= 1'b0;
          dbl_colon_q  <= 1'b0;
          any_colon_q  <= 1'b0;
          port_value_q <= '0;
          port_digit_q <= 1'b0;
        end else begin
          phase_q      <= phase_d;
          prev_colon_q <= prev_colon_d;
          dbl_colon_q  <= dbl_colon_d;
          any_colon_q  <= any_colon_d;
          port_value_q <= port_value_d;
          port_digit_q <= port_digit_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    host_ok_q <= host_ok_d;
  end

  assign out_valid_o = out_valid_q;
  assign host_ok_o   = host_ok_q;

  // a final byte always leaves a verdict waiting
  a_eos_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_string_i) |=> out_valid_q)
    else $error("final item did not produce a verdict");

  // a final byte puts the parser back to its reset state
  a_eos_resets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_string_i) |=> (phase_q == PhOpen))
    else $error("parser not reset after final item");

  // waiting for the opening bracket implies all tracking state is clear
  a_open_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhOpen) |-> (!prev_colon_q && !dbl_colon_q && !any_colon_q &&
                             !port_digit_q && (port_value_q == '0)))
    else $error("stale state while waiting for opening bracket");

  // port digits only ever arrive in the port phase
  a_digit_in_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_digit_q |-> ((phase_q == PhPort) || (phase_q == PhBad)))
    else $error("port digit flag outside port phase");

  // input is held off only while a verdict is waiting
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no verdict waiting");

endmodule

// ===== tb/sv/ipv6hv_checker.sv =====
// bracketed ipv6 host checker: tracks the parse of every accepted byte and compares verdicts
// depends on ipv6hv_pkg; watches both channels of ipv6_host_validator
`timescale 1ns / 100ps

module ipv6hv_checker import ipv6hv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_string_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       host_ok_i,
  input  logic       drain_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct {
    phase_e          ph;
    logic            after_colon;
    logic            pair_seen;
    logic            colon_seen;
    logic [15:0]     port_val;
    logic            port_digit;
  } host_parse_t;

  host_parse_t parse;
  logic        verdicts_due[$];
  logic        due;

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic host_parse_t fresh_parse();
    host_parse_t s;
    s.ph          = PhOpen;
    s.after_colon = 1'b0;
    s.pair_seen   = 1'b0;
    s.colon_seen  = 1'b0;
    s.port_val    = '0;
    s.port_digit  = 1'b0;
    return s;
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return !(c < CharZero) && !(c > CharNine);
  endfunction

  // folding bit 5 maps upper case letters onto lower case
  function automatic logic hex_digit(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    return dec_digit(c) || (folded >= CharLowA && folded <= CharLowF);
  endfunction

  function automatic host_parse_t advance_parse(input host_parse_t s, input logic [7:0] c);
    host_parse_t n;
    logic [31:0] widened;
    n = s;
    case (s.ph)
      PhOpen: begin
        n.ph = (c == CharOpen) ? PhInside : PhBad;
      end
      PhInside: begin
        if (c == CharClose) begin
          n.ph = s.colon_seen ? PhClosed : PhBad;
        end else if (c == CharColon) begin
          if (s.after_colon) begin
            // a second pair of adjacent colons, three in a row too
            if (s.pair_seen) n.ph = PhBad;
            n.pair_seen = 1'b1;
          end
          n.colon_seen  = 1'b1;
          n.after_colon = 1'b1;
        end else if (hex_digit(c)) begin
          n.after_colon = 1'b0;
        end else begin
          n.ph = PhBad;
        end
      end
      PhClosed: begin
        n.ph = (c == CharColon) ? PhPort : PhBad;
      end
      PhPort: begin
        if (dec_digit(c)) begin
          widened = {16'd0, s.port_val} * 32'd10 + {24'd0, c} - {24'd0, CharZero};
          n.port_val   = (widened > {16'd0, PortMax}) ? PortMax : widened[15:0];
          n.port_digit = 1'b1;
        end else begin
          n.ph = PhBad;
        end
      end
      default: begin
        n.ph = PhBad;
      end
    endcase
    return n;
  endfunction

  function automatic logic host_verdict(input host_parse_t s);
    if (s.ph == PhClosed) return 1'b1;
    return (s.ph == PhPort) && s.port_digit && (s.port_val > 16'd1) && (s.port_val < PortMax);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse = fresh_parse();
      verdicts_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse = advance_parse(parse, char_byte_i);
        if (end_of_string_i) begin
          verdicts_due.push_back(host_verdict(parse));
          parse = fresh_parse();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict host_ok=%b with no string ended", host_ok_i));
        end else begin
          due = verdicts_due.pop_front();
          if (host_ok_i !== due)
            report_mismatch($sformatf("host_ok=%b, expected %b", host_ok_i, due));
        end
      end
    end
    pending_o = verdicts_due.size();
  end

  always @(posedge drain_i) begin
    if (verdicts_due.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
  end

endmodule

// ===== tb/sv/tb.sv =====
// top of the ipv6 host validator bench: clock, reset, host string stimulus and the verdict
// depends on ipv6hv_pkg, ipv6_host_validator and ipv6hv_checker
`timescale 1ns / 100ps

module tb;
  import ipv6hv_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       host_ok;
  logic       drain = 1'b0;
  int         fail_count;
  int         pending;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_off = 1'b0;
  logic       random_on = 1'b0;
  logic [7:0] text_q[$];
  int         random_bytes = 0;

  always #5 clk_i = ~clk_i;

  ipv6_host_validator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .char_byte_i     (char_byte),
    .end_of_string_i (end_of_string),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .host_ok_o       (host_ok)
  );

  ipv6hv_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .char_byte_i     (char_byte),
    .end_of_string_i (end_of_string),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .host_ok_i       (host_ok),
    .drain_i         (drain),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  function automatic logic chance(input int pct);
    return int'($urandom_range(0, 99)) < pct;
  endfunction

  function automatic logic [7:0] hex_char();
    string set;
    set = "0123456789abcdefABCDEF";
    return set[$urandom_range(0, 21)];
  endfunction

  // mostly the bytes that steer the parser, the rest anything at all
  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 5))
      0: return CharOpen;
      1: return CharClose;
      2: return CharColon;
      3: return hex_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (chance(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    char_byte     <= b;
    end_of_string <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_str(input string s);
    add_str(s);
    send_text();
  endtask

  task automatic build_random_text();
    int          groups;
    int          pair_at;
    int          port_kind;
    int          pos;
    int unsigned port_num;
    string       port_txt;
    if (chance(10)) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(odd_byte());
      return;
    end
    text_q.push_back(CharOpen);
    groups  = $urandom_range(0, 5);
    pair_at = chance(50) ? int'($urandom_range(0, groups)) : -1;
    for (int g = 0; g <= groups; g++) begin
      if (g == pair_at) text_q.push_back(CharColon);
      if (g > 0) text_q.push_back(CharColon);
      repeat ($urandom_range(0, 4)) text_q.push_back(hex_char());
    end
    text_q.push_back(CharClose);
    port_kind = $urandom_range(0, 9);
    if (port_kind >= 3) begin
      text_q.push_back(CharColon);
      case ($urandom_range(0, 3))
        0: port_num = $urandom_range(0, 9);
        1: begin
          case ($urandom_range(0, 6))
            0: port_num = 0;
            1: port_num = 1;
            2: port_num = 2;
            3: port_num = 65534;
            4: port_num = 65535;
            5: port_num = 65536;
            default: port_num = 99999;
          endcase
        end
        2: port_num = $urandom_range(0, 65535);
        default: port_num = $urandom_range(0, 9999999);
      endcase
      port_txt = $sformatf("%0d", port_num);
      if (chance(15)) port_txt = {"00", port_txt};
      // a colon with nothing after it now and then
      if (port_kind != 3) add_str(port_txt);
    end
    if (chance(25)) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0: text_q[pos] = odd_byte();
        1: text_q.insert(pos, CharColon);
        default: while (text_q.size() > pos + 1) text_q.delete(text_q.size() - 1);
      endcase
    end
  endtask

  // receiver stalls at random, or solidly while a hold-off is on
  initial begin
    forever begin
      @(posedge clk_i);
      out_stall <= hold_off || chance(recv_stall_pct);
    end
  end

  // long hold-off so the output register fills and the input backs up
  initial begin
    wait (random_on);
    hold_off = 1'b1;
    repeat (120) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_str("[::1]");
    send_str("[]");
    send_str("[");
    send_str("[::1]:");
    send_str("[::1]:65535");
    send_str("[::1]:99999");
    send_str("[::1]:0080");
    send_str("[::1]:1");
    send_str("[:]:2");
    send_str("[a:::b]");
    send_str("[::1::2]");
    send_str("[fF:Aa]]");
    send_str("[9:g]");
    send_str("[1:2]x");
    text_q.push_back(8'h00);
    send_text();
    text_q.push_back(CharOpen);
    text_q.push_back(8'hFF);
    add_str(":]");
    send_text();
    send_str("[0:9]:65534");

    random_on = 1'b1;
    while (random_bytes < 1050) begin
      case (random_bytes / 263)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      build_random_text();
      random_bytes += text_q.size();
      send_text();
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    drain <= 1'b1;
    @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
